FILE: hdl/zmrd_pkg.sv
package zmrd_pkg;

    localparam int MaxSubpacket = 1024;
    localparam int CountW = $clog2(MaxSubpacket + 2);

    // received byte codes
    localparam logic [7:0] ZPAD  = 8'h2a;
    localparam logic [7:0] ZDLE  = 8'h18;
    localparam logic [6:0] XON   = 7'h11;
    localparam logic [6:0] XOFF  = 7'h13;
    localparam logic [7:0] ZCRCE = 8'h68;
    localparam logic [7:0] ZCRCW = 8'h6b;
    localparam logic [7:0] ZRUB0 = 8'h6c;
    localparam logic [7:0] ZRUB1 = 8'h6d;
    localparam logic [7:0] FORM_BIN16 = 8'h41;
    localparam logic [7:0] FORM_HEX16 = 8'h42;
    localparam logic [7:0] FORM_BIN32 = 8'h43;
    localparam logic [7:0] CHAR_O = 8'h4f;
    localparam logic [6:0] CHAR_CR = 7'h0d;
    localparam logic [6:0] CHAR_LF = 7'h0a;
    localparam logic [7:0] TYPE_FIN = 8'd8;

    // event codes
    localparam logic [2:0] EV_HDR    = 3'd0;
    localparam logic [2:0] EV_NAK    = 3'd1;
    localparam logic [2:0] EV_DATA   = 3'd2;
    localparam logic [2:0] EV_END    = 3'd3;
    localparam logic [2:0] EV_CANCEL = 3'd4;
    localparam logic [2:0] EV_FINISH = 3'd5;

    // header forms
    localparam logic [1:0] HF_BIN16 = 2'd0;
    localparam logic [1:0] HF_HEX16 = 2'd1;
    localparam logic [1:0] HF_BIN32 = 2'd2;

    typedef struct packed {
        logic [7:0] b;
        logic       is_zdle;
    } t_tok;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  header_type;
        logic [31:0] header_args;
        logic [1:0]  header_form;
        logic [7:0]  data_out;
        logic [1:0]  end_kind;
        logic        crc_good;
        logic [10:0] sub_length;
        logic        overflow;
    } t_res;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
        end
        return x;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ 32'hedb88320) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = (b < 8'h61) ? (b - 8'h30) : (b - 8'h57);
        return v[3:0];
    endfunction

endpackage

FILE: hdl/zmrd_in_if.sv
interface zmrd_in_if;
    import zmrd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/zmrd_out_if.sv
interface zmrd_out_if;
    import zmrd_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  header_type;
    logic [31:0] header_args;
    logic [1:0]  header_form;
    logic [7:0]  data_out;
    logic [1:0]  end_kind;
    logic        crc_good;
    logic [10:0] sub_length;
    logic        overflow;
    modport source (output valid, output event_res, output header_type, output header_args,
        output header_form, output data_out, output end_kind, output crc_good,
        output sub_length, output overflow, input ready);
    modport sink (input valid, input event_res, input header_type, input header_args,
        input header_form, input data_out, input end_kind, input crc_good,
        input sub_length, input overflow, output ready);
endinterface

FILE: hdl/zmrd_cfg_if.sv
interface zmrd_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/zmrd_front.sv
module zmrd_front
    import zmrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_tok_valid,
    input  logic       i_tok_ready,
    output t_tok       o_tok
);

    logic       r_full, n_full;
    t_tok       r_tok, n_tok;
    logic       take;

    // one-entry queue slot toward the back end
    assign o_ready     = !r_full || i_tok_ready;
    assign o_tok_valid = r_full;
    assign o_tok       = r_tok;
    assign take        = i_valid && o_ready;

    // classify: flow-control bytes are dropped, escape bytes are tagged
    always_comb begin
        n_full = r_full && !i_tok_ready;
        n_tok  = r_tok;
        if (take && i_byte[6:0] != XON && i_byte[6:0] != XOFF) begin
            n_full        = 1'b1;
            n_tok.b       = i_byte;
            n_tok.is_zdle = (i_byte == ZDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full    <= 1'b0;
        end else begin
            r_full    <= n_full;
        end
        r_tok <= n_tok;
    end

endmodule

FILE: hdl/zmrd_back.sv
module zmrd_back
    import zmrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [19:0] i_mask,
    input  logic        i_tok_valid,
    output logic        o_tok_ready,
    input  t_tok        i_tok,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_res        o_res
);

    localparam logic [3:0] S_IDLE = 4'd0, S_HEADER = 4'd1, S_HEX = 4'd2, S_HEX_CRC = 4'd3,
        S_HEX_CRLF = 4'd4, S_BIN = 4'd5, S_BIN32 = 4'd6, S_BIN_CRC = 4'd7,
        S_BIN32_CRC = 4'd8, S_DATA = 4'd9, S_DCRC = 4'd10, S_FINISH = 4'd11,
        S_CHECK = 4'd12;

    logic [3:0]        r_st, n_st;
    logic [CountW-1:0] r_cnt, n_cnt;
    logic [39:0]       r_hdr, n_hdr;
    logic [31:0]       r_rcrc, n_rcrc;
    logic [31:0]       r_crc, n_crc;
    logic [1:0]        r_term, n_term;
    logic              r_wide, n_wide;
    logic [1:0]        r_form, n_form;
    logic [1:0]        r_didx, n_didx;
    logic [2:0]        r_esc_run, n_esc_run;
    logic              r_ov, n_ov;
    t_res              r_res, n_res;
    logic              emit, go;
    t_res              res;
    logic              esc;
    logic [7:0]        ub;
    logic [7:0]        b;
    logic [3:0]        hv;
    logic [2:0]        hidx;
    logic [15:0]       c16;
    logic [31:0]       c32;
    logic              hgood;

    // unescape when the previous beat was an escape
    assign esc = (r_esc_run != 3'd0);
    always_comb begin
        ub = i_tok.b;
        if (i_tok.b == ZRUB0) ub = 8'h7f;
        else if (i_tok.b == ZRUB1) ub = 8'hff;
        else if ((i_tok.b & 8'h60) == 8'h40) ub = i_tok.b ^ 8'h40;
    end
    assign b  = esc ? ub : i_tok.b;
    assign hv = hex_val(b);

    // output register: the next result may enter while this one is taken
    assign o_res_valid = r_ov;
    assign o_res       = r_res;
    assign o_tok_ready = (!r_ov || i_res_ready) && (r_st != S_CHECK);
    assign go          = i_tok_valid && o_tok_ready;

    // header crc over the stored header (check cycle)
    always_comb begin
        c16 = 16'h0;
        c32 = 32'hffffffff;
        for (int i = 0; i < 5; i++) begin
            c16 = crc16_byte(c16, r_hdr[8*i +: 8]);
            c32 = crc32_byte(c32, r_hdr[8*i +: 8]);
        end
        hgood = (r_form == HF_BIN32) ? (~c32 == r_rcrc) : (c16 == r_rcrc[15:0]);
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_hdr = r_hdr; n_rcrc = r_rcrc; n_crc = r_crc;
        n_term = r_term; n_wide = r_wide; n_form = r_form; n_didx = r_didx;
        n_esc_run = r_esc_run;
        emit = 1'b0;
        res  = '0;
        hidx = r_cnt[3:1];
        if (r_st == S_CHECK) begin
            if (!r_ov || i_res_ready) begin
                emit = 1'b1;
                n_cnt = '0;
                if (!hgood) begin
                    res.event_res = EV_NAK;
                    n_st = S_IDLE;
                end else begin
                    res.event_res   = EV_HDR;
                    res.header_type = r_hdr[7:0];
                    res.header_args = r_hdr[39:8];
                    res.header_form = r_form;
                    if (r_hdr[7:0] == TYPE_FIN) n_st = S_FINISH;
                    else if (r_hdr[7:0] < 8'd20 && i_mask[r_hdr[4:0]]) begin
                        n_wide = (r_form == HF_BIN32);
                        n_st   = S_DATA;
                        n_crc  = (r_form == HF_BIN32) ? 32'hffffffff : 32'h0;
                    end else n_st = S_IDLE;
                end
            end
        end else if (go) begin
            if (i_tok.is_zdle) begin
                // escape run: five in a row cancel, one after pads starts a header
                n_esc_run = (r_esc_run < 3'd7) ? r_esc_run + 3'd1 : r_esc_run;
                if (n_esc_run >= 3'd5) begin
                    n_esc_run = 3'd0;
                    emit = 1'b1; res.event_res = EV_CANCEL; n_st = S_IDLE; n_cnt = '0;
                end else if (r_st == S_IDLE && r_cnt != '0) begin
                    n_esc_run = 3'd0; n_st = S_HEADER; n_cnt = '0;
                end
            end else begin
                n_esc_run = 3'd0;
                unique case (r_st)
                    S_IDLE: begin
                        if (b == ZPAD) n_cnt = (r_cnt < 2) ? r_cnt + 1'b1 : r_cnt;
                        else n_cnt = '0;
                    end
                    S_HEADER: begin
                        n_cnt = '0; n_rcrc = '0;
                        if (b == FORM_HEX16) begin n_st = S_HEX; n_form = HF_HEX16; end
                        else if (b == FORM_BIN16) begin n_st = S_BIN; n_form = HF_BIN16; end
                        else if (b == FORM_BIN32) begin n_st = S_BIN32; n_form = HF_BIN32; end
                        else begin emit = 1'b1; res.event_res = EV_NAK; n_st = S_IDLE; end
                    end
                    S_HEX: begin
                        if (!is_hex(b)) begin
                            emit = 1'b1; res.event_res = EV_NAK; n_st = S_IDLE; n_cnt = '0;
                        end else begin
                            if (r_cnt[0]) n_hdr[8*hidx +: 8] = r_hdr[8*hidx +: 8] | {4'h0, hv};
                            else n_hdr[8*hidx +: 8] = {hv, 4'h0};
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == 9) begin n_st = S_HEX_CRC; n_cnt = '0; n_rcrc = '0; end
                        end
                    end
                    S_HEX_CRC: begin
                        if (!is_hex(b)) begin
                            emit = 1'b1; res.event_res = EV_NAK; n_st = S_IDLE; n_cnt = '0;
                        end else begin
                            n_rcrc = {16'h0, r_rcrc[11:0], hv};
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == 3) begin n_st = S_HEX_CRLF; n_cnt = '0; end
                        end
                    end
                    S_HEX_CRLF: begin
                        if (r_cnt == '0 && b[6:0] == CHAR_CR) n_cnt = CountW'(1);
                        else if (r_cnt == 1 && b[6:0] == CHAR_LF) n_st = S_CHECK;
                        else begin emit = 1'b1; res.event_res = EV_NAK; n_st = S_IDLE; n_cnt = '0; end
                    end
                    S_BIN, S_BIN32: begin
                        n_hdr[8*r_cnt[2:0] +: 8] = b;
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == 4) begin
                            n_st = (r_st == S_BIN32) ? S_BIN32_CRC : S_BIN_CRC;
                            n_cnt = '0; n_rcrc = '0;
                        end
                    end
                    S_BIN_CRC: begin
                        n_rcrc = {16'h0, r_rcrc[7:0], b};
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == 1) n_st = S_CHECK;
                    end
                    S_BIN32_CRC: begin
                        n_rcrc[8*r_cnt[1:0] +: 8] = b;
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == 3) n_st = S_CHECK;
                    end
                    S_DATA: begin
                        n_crc = r_wide ? crc32_byte(r_crc, b) : {16'h0, crc16_byte(r_crc[15:0], b)};
                        if (esc && b >= ZCRCE && b <= ZCRCW) begin
                            n_term = b[1:0] - ZCRCE[1:0];
                            n_st = S_DCRC; n_didx = 2'd0; n_rcrc = '0;
                        end else begin
                            if (r_cnt <= MaxSubpacket) n_cnt = r_cnt + 1'b1;
                            if (r_cnt < MaxSubpacket) begin
                                emit = 1'b1; res.event_res = EV_DATA; res.data_out = b;
                            end
                        end
                    end
                    S_DCRC: begin
                        if (r_wide) n_rcrc[8*r_didx +: 8] = b;
                        else n_rcrc = {16'h0, r_rcrc[7:0], b};
                        n_didx = r_didx + 2'd1;
                        if ((r_wide && r_didx == 2'd3) || (!r_wide && r_didx == 2'd1)) begin
                            emit = 1'b1;
                            res.event_res = EV_END;
                            res.end_kind  = r_term;
                            res.crc_good  = r_wide ? (~r_crc == n_rcrc) : (r_crc == n_rcrc);
                            res.sub_length = (r_cnt > MaxSubpacket) ? 11'(MaxSubpacket)
                                                                    : 11'(r_cnt);
                            res.overflow  = (r_cnt > MaxSubpacket);
                            n_cnt = '0;
                            if (r_term == 2'd1) begin
                                n_st = S_DATA;
                                n_crc = r_wide ? 32'hffffffff : 32'h0;
                            end else n_st = S_IDLE;
                        end
                    end
                    S_FINISH: begin
                        if (b == CHAR_O) n_cnt = r_cnt + 1'b1;
                        else n_cnt = '0;
                        if (b == CHAR_O && r_cnt >= 1) begin
                            emit = 1'b1; res.event_res = EV_FINISH; n_st = S_IDLE; n_cnt = '0;
                        end
                    end
                    default: begin n_st = S_IDLE; n_cnt = '0; end
                endcase
            end
        end
        n_ov  = emit ? 1'b1 : (r_ov && !i_res_ready);
        n_res = emit ? res : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ov <= 1'b0; r_wide <= 1'b0;
            r_hdr <= '0; r_rcrc <= '0; r_crc <= '0; r_term <= '0; r_esc_run <= 3'd0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ov <= n_ov; r_wide <= n_wide;
            r_hdr <= n_hdr; r_rcrc <= n_rcrc; r_crc <= n_crc; r_term <= n_term;
            r_esc_run <= n_esc_run;
        end
        r_form <= n_form;
        r_didx <= n_didx;
        r_res  <= n_res;
    end

endmodule

FILE: hdl/zmodem_receive_deframer_core.sv
// zmodem receive deframer
// path: front slot, back end result register; a header also passes the check state
// throughput: one byte per cycle unless the output stalls; in the check state
//   no byte is taken, for the header crc check over the five stored bytes
// reset: synchronous active low; clears state, queue and output; mask to 0x414
module zmodem_receive_deframer_core
    import zmrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    zmrd_cfg_if.sink  cfg,
    zmrd_in_if.sink   in_ch,
    zmrd_out_if.source out_ch
);

    logic [19:0] r_mask;
    logic        tok_valid, tok_ready;
    t_tok        tok;
    t_res        res;

    // configuration register
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 20'h00414;
        end else if (cfg.valid) begin
            r_mask <= cfg.data;
        end
    end

    zmrd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_byte(in_ch.rx_byte),
        .o_tok_valid(tok_valid), .i_tok_ready(tok_ready), .o_tok(tok)
    );

    zmrd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mask(r_mask),
        .i_tok_valid(tok_valid), .o_tok_ready(tok_ready), .i_tok(tok),
        .o_res_valid(out_ch.valid), .i_res_ready(out_ch.ready), .o_res(res)
    );

    assign out_ch.event_res   = res.event_res;
    assign out_ch.header_type = res.header_type;
    assign out_ch.header_args = res.header_args;
    assign out_ch.header_form = res.header_form;
    assign out_ch.data_out    = res.data_out;
    assign out_ch.end_kind    = res.end_kind;
    assign out_ch.crc_good    = res.crc_good;
    assign out_ch.sub_length  = res.sub_length;
    assign out_ch.overflow    = res.overflow;

endmodule

FILE: test/tb_zmodem_receive_deframer_core.sv
`timescale 1ns / 1ps

module tb_zmodem_receive_deframer_core;
    import zmrd_pkg::*;

    localparam int IdleLimit = 20000;
    localparam logic [4:0] ST_IDLE = 5'd0, ST_HEADER = 5'd1, ST_HEX = 5'd2,
        ST_HEX_CRC = 5'd3, ST_HEX_CRLF = 5'd4, ST_BIN = 5'd5, ST_BIN32 = 5'd6,
        ST_BIN_CRC = 5'd7, ST_BIN32_CRC = 5'd8, ST_DATA = 5'd9, ST_DCRC0 = 5'd10,
        ST_FINISH = 5'd14;
    localparam logic [7:0] CHAR_CR8 = 8'h0d;
    localparam logic [7:0] CHAR_LF8 = 8'h0a;

    // deframer predictor plus queue of expected events
    class deframer_scoreboard;
        logic [19:0] mask;
        logic [4:0]  fstate;
        logic [10:0] count;
        logic [2:0]  esc_run;
        logic [39:0] hdr;
        logic [31:0] rcrc;
        logic [31:0] run_crc;
        logic [1:0]  term;
        logic        wide;
        t_res        pending[$];
        int          errors;
        int          n_events;

        function new();
            mask = 20'h00414; fstate = ST_IDLE; count = 0; esc_run = 0;
            hdr = 0; rcrc = 0; run_crc = 0; term = 0; wide = 0;
            errors = 0; n_events = 0;
        endfunction

        function automatic logic [15:0] crc16(logic [15:0] c, logic [7:0] b);
            logic [15:0] x;
            x = c ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
            return x;
        endfunction

        function automatic logic [31:0] crc32(logic [31:0] c, logic [7:0] b);
            logic [31:0] x;
            x = c ^ {24'h0, b};
            for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 32'hedb88320) : (x >> 1);
            return x;
        endfunction

        function automatic bit hexdig(logic [7:0] b);
            return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66);
        endfunction

        function automatic logic [3:0] hexnib(logic [7:0] b);
            return (b < 8'h61) ? b[3:0] : (b[3:0] + 4'd9);
        endfunction

        function void push(t_res r);
            pending.push_back(r);
        endfunction

        function void bad_header();
            t_res r;
            r = '0;
            r.event_res = EV_NAK;
            fstate = ST_IDLE; count = 0;
            push(r);
        endfunction

        function void start_data();
            fstate = ST_DATA; count = 0;
            run_crc = wide ? 32'hffffffff : 32'h0;
        endfunction

        function void check_header(logic [1:0] form);
            logic [31:0] c;
            bit good;
            t_res r;
            c = (form == HF_BIN32) ? 32'hffffffff : 32'h0;
            for (int i = 0; i < 5; i++)
                c = (form == HF_BIN32) ? crc32(c, hdr[8*i +: 8])
                                       : {16'h0, crc16(c[15:0], hdr[8*i +: 8])};
            good = (form == HF_BIN32) ? (~c == rcrc) : (c[15:0] == rcrc[15:0]);
            if (!good) begin
                bad_header();
                return;
            end
            r = '0;
            r.event_res = EV_HDR;
            r.header_type = hdr[7:0];
            r.header_args = hdr[39:8];
            r.header_form = form;
            push(r);
            if (hdr[7:0] == TYPE_FIN) begin
                fstate = ST_FINISH; count = 0;
            end else if (hdr[7:0] < 20 && mask[hdr[4:0]]) begin
                wide = (form == HF_BIN32);
                start_data();
            end else begin
                fstate = ST_IDLE; count = 0;
            end
        endfunction

        // note an accepted byte
        function void note_byte(logic [7:0] raw);
            logic [7:0] b;
            bit esc;
            int idx;
            t_res r;
            b = raw;
            r = '0;
            if (b[6:0] == XON || b[6:0] == XOFF) return;
            if (b == ZDLE) begin
                if (esc_run < 7) esc_run++;
                if (esc_run >= 5) begin
                    esc_run = 0; fstate = ST_IDLE; count = 0;
                    r.event_res = EV_CANCEL;
                    push(r);
                end else if (fstate == ST_IDLE && count != 0) begin
                    esc_run = 0; fstate = ST_HEADER; count = 0;
                end
                return;
            end
            esc = esc_run != 0;
            esc_run = 0;
            if (esc) begin
                if (b == ZRUB0) b = 8'h7f;
                else if (b == ZRUB1) b = 8'hff;
                else if ((b & 8'h60) == 8'h40) b ^= 8'h40;
            end
            case (fstate)
                ST_IDLE: count = (b == ZPAD) ? ((count < 2) ? count + 11'd1 : count) : 11'd0;
                ST_HEADER: begin
                    count = 0; rcrc = 0;
                    if (b == FORM_HEX16) fstate = ST_HEX;
                    else if (b == FORM_BIN16) fstate = ST_BIN;
                    else if (b == FORM_BIN32) fstate = ST_BIN32;
                    else bad_header();
                end
                ST_HEX: begin
                    if (!hexdig(b)) begin
                        bad_header();
                        return;
                    end
                    idx = (count >> 1) % 5;
                    if (count[0]) hdr[8*idx +: 4] = hexnib(b);
                    else hdr[8*idx +: 8] = {hexnib(b), 4'h0};
                    count++;
                    if (count >= 10) begin
                        fstate = ST_HEX_CRC; count = 0; rcrc = 0;
                    end
                end
                ST_HEX_CRC: begin
                    if (!hexdig(b)) begin
                        bad_header();
                        return;
                    end
                    rcrc = {16'h0, rcrc[11:0], hexnib(b)};
                    count++;
                    if (count >= 4) begin
                        fstate = ST_HEX_CRLF; count = 0;
                    end
                end
                ST_HEX_CRLF: begin
                    if (count == 0 && b[6:0] == CHAR_CR) count = 11'd1;
                    else if (count == 1 && b[6:0] == CHAR_LF) check_header(HF_HEX16);
                    else bad_header();
                end
                ST_BIN, ST_BIN32: begin
                    hdr[8*(count % 5) +: 8] = b;
                    count++;
                    if (count >= 5) begin
                        fstate = (fstate == ST_BIN32) ? ST_BIN32_CRC : ST_BIN_CRC;
                        count = 0; rcrc = 0;
                    end
                end
                ST_BIN_CRC: begin
                    rcrc = {16'h0, rcrc[7:0], b};
                    count++;
                    if (count >= 2) check_header(HF_BIN16);
                end
                ST_BIN32_CRC: begin
                    rcrc[8*count[1:0] +: 8] = b;
                    count++;
                    if (count >= 4) check_header(HF_BIN32);
                end
                ST_DATA: begin
                    run_crc = wide ? crc32(run_crc, b) : {16'h0, crc16(run_crc[15:0], b)};
                    if (esc && b >= ZCRCE && b <= ZCRCW) begin
                        term = 2'(b - ZCRCE); fstate = ST_DCRC0; rcrc = 0;
                        return;
                    end
                    if (count <= MaxSubpacket) count++;
                    if (count <= MaxSubpacket) begin
                        r.event_res = EV_DATA;
                        r.data_out = b;
                        push(r);
                    end
                end
                ST_DCRC0, ST_DCRC0 + 5'd1, ST_DCRC0 + 5'd2, ST_DCRC0 + 5'd3: begin
                    idx = fstate - ST_DCRC0;
                    if (wide) rcrc[8*idx +: 8] = b;
                    else rcrc = {16'h0, rcrc[7:0], b};
                    if (idx + 1 < (wide ? 4 : 2)) begin
                        fstate++;
                        return;
                    end
                    r.event_res = EV_END;
                    r.end_kind = term;
                    r.crc_good = wide ? (~run_crc == rcrc) : (run_crc[15:0] == rcrc[15:0]);
                    r.sub_length = (count > MaxSubpacket) ? 11'(MaxSubpacket) : count;
                    r.overflow = count > MaxSubpacket;
                    push(r);
                    if (term == 2'd1) start_data();
                    else begin
                        fstate = ST_IDLE; count = 0;
                    end
                end
                ST_FINISH: begin
                    count = (b == CHAR_O) ? count + 11'd1 : 11'd0;
                    if (count >= 2) begin
                        fstate = ST_IDLE; count = 0;
                        r.event_res = EV_FINISH;
                        push(r);
                    end
                end
                default: begin
                    fstate = ST_IDLE; count = 0;
                end
            endcase
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_event(t_res got);
            t_res want;
            n_events++;
            if (pending.size() == 0) begin
                report("unexpected event", got.event_res, 0);
                return;
            end
            want = pending.pop_front();
            if (got.event_res !== want.event_res)
                report("event_res", got.event_res, want.event_res);
            if (got.header_type !== want.header_type)
                report("header_type", got.header_type, want.header_type);
            if (got.header_args !== want.header_args)
                report("header_args", got.header_args, want.header_args);
            if (got.header_form !== want.header_form)
                report("header_form", got.header_form, want.header_form);
            if (got.data_out !== want.data_out)
                report("data_out", got.data_out, want.data_out);
            if (got.end_kind !== want.end_kind)
                report("end_kind", got.end_kind, want.end_kind);
            if (got.crc_good !== want.crc_good)
                report("crc_good", got.crc_good, want.crc_good);
            if (got.sub_length !== want.sub_length)
                report("sub_length", got.sub_length, want.sub_length);
            if (got.overflow !== want.overflow)
                report("overflow", got.overflow, want.overflow);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    zmrd_cfg_if cfg();
    zmrd_in_if  in_ch();
    zmrd_out_if out_ch();

    zmodem_receive_deframer_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cfg    (cfg.sink),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    deframer_scoreboard sb = new();
    logic [7:0] frame_q[$];
    int  burst_left = 0;
    int  idle_cycles = 0;
    int  n_bytes = 0;
    bit  timed_out = 0;
    bit  stall_en = 1;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        cfg.valid = 1'b0;
        cfg.data = '0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = '0;
        out_ch.ready = 1'b0;
    end

    // receiver stall pattern plus result checking
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_event(t_res'{out_ch.event_res, out_ch.header_type, out_ch.header_args,
                out_ch.header_form, out_ch.data_out, out_ch.end_kind, out_ch.crc_good,
                out_ch.sub_length, out_ch.overflow});
        out_ch.ready <= !stall_en || ($urandom_range(0, 7) > 2 && !($time % 184 < 24));
    end

    // watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit && !timed_out) begin
            timed_out = 1;
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // send one byte, honoring bursts and gaps; valid stays up between back-to-back bytes
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b);
        n_bytes++;
        burst_left--;
    endtask

    task automatic send_queue();
        while (frame_q.size() > 0) send_byte(frame_q.pop_front());
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [19:0] m);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= m;
        do @(posedge i_clk); while (!cfg.ready);
        sb.mask = m;
        cfg.valid <= 1'b0;
    endtask

    // escape a byte for the link the way a sender would
    function automatic void put_escaped(logic [7:0] b);
        if (b == ZDLE || b[6:0] == XON || b[6:0] == XOFF || b == 8'h7f || b == 8'hff) begin
            frame_q.push_back(ZDLE);
            frame_q.push_back(b == 8'h7f ? ZRUB0 : b == 8'hff ? ZRUB1 : b ^ 8'h40);
        end else frame_q.push_back(b);
    endfunction

    function automatic void put_hex(logic [7:0] b);
        logic [3:0] n;
        for (int i = 1; i >= 0; i--) begin
            n = b[4*i +: 4];
            frame_q.push_back(n < 10 ? 8'h30 + n : 8'h57 + n);
        end
    endfunction

    // build a header; corrupt flips the crc
    function automatic void put_header(logic [1:0] form, logic [7:0] ftype,
            logic [31:0] args, bit corrupt);
        logic [39:0] h;
        logic [31:0] c;
        h = {args, ftype};
        frame_q.push_back(ZPAD);
        if ($urandom_range(0, 1)) frame_q.push_back(ZPAD);
        frame_q.push_back(ZDLE);
        frame_q.push_back(form == HF_BIN16 ? FORM_BIN16 : form == HF_HEX16 ? FORM_HEX16
                                                                           : FORM_BIN32);
        c = (form == HF_BIN32) ? 32'hffffffff : 0;
        for (int i = 0; i < 5; i++)
            c = (form == HF_BIN32) ? sb.crc32(c, h[8*i +: 8])
                                   : {16'h0, sb.crc16(c[15:0], h[8*i +: 8])};
        if (form == HF_BIN32) c = ~c;
        if (corrupt) c ^= 32'h1 << $urandom_range(0, 15);
        if (form == HF_HEX16) begin
            for (int i = 0; i < 5; i++) put_hex(h[8*i +: 8]);
            put_hex(c[15:8]);
            put_hex(c[7:0]);
            frame_q.push_back($urandom_range(0, 1) ? CHAR_CR8 : CHAR_CR8 | 8'h80);
            frame_q.push_back(CHAR_LF8);
        end else begin
            for (int i = 0; i < 5; i++) put_escaped(h[8*i +: 8]);
            if (form == HF_BIN32) for (int i = 0; i < 4; i++) put_escaped(c[8*i +: 8]);
            else begin
                put_escaped(c[15:8]);
                put_escaped(c[7:0]);
            end
        end
    endfunction

    // build a data subpacket of len random bytes
    function automatic void put_subpacket(bit wide, int len, logic [1:0] kind, bit corrupt);
        logic [31:0] c;
        logic [7:0] b;
        c = wide ? 32'hffffffff : 0;
        for (int i = 0; i < len; i++) begin
            b = $urandom_range(0, 7) == 0 ? ZDLE : 8'($urandom_range(0, 255));
            put_escaped(b);
            c = wide ? sb.crc32(c, b) : {16'h0, sb.crc16(c[15:0], b)};
        end
        b = ZCRCE + kind;
        frame_q.push_back(ZDLE);
        frame_q.push_back(b);
        c = wide ? sb.crc32(c, b) : {16'h0, sb.crc16(c[15:0], b)};
        if (wide) c = ~c;
        if (corrupt) c ^= 32'h1 << $urandom_range(0, 15);
        if (wide) for (int i = 0; i < 4; i++) put_escaped(c[8*i +: 8]);
        else begin
            put_escaped(c[15:8]);
            put_escaped(c[7:0]);
        end
    endfunction

    // a header with its subpackets, as the mask decides
    task automatic send_frame(logic [1:0] form, logic [7:0] ftype, int maxlen);
        bit data;
        int nsub;
        data = ftype != TYPE_FIN && ftype < 20 && sb.mask[ftype[4:0]];
        put_header(form, ftype, $urandom, $urandom_range(0, 9) == 0);
        send_queue();
        if (sb.fstate == ST_DATA) begin
            nsub = $urandom_range(1, 3);
            for (int i = 0; i < nsub; i++)
                put_subpacket(form == HF_BIN32, $urandom_range(0, maxlen),
                    i == nsub - 1 ? ($urandom_range(0, 2) == 0 ? 2'd0
                                                              : 2'($urandom_range(2, 3)))
                                  : 2'd1,
                    $urandom_range(0, 9) == 0);
        end else if (sb.fstate == ST_FINISH) begin
            if ($urandom_range(0, 1)) frame_q.push_back(8'h41);
            frame_q.push_back(CHAR_O);
            frame_q.push_back(CHAR_O);
        end
        if (data && $urandom_range(0, 15) == 0) begin
            for (int i = 0; i < 5; i++) frame_q.push_back(ZDLE);
        end
        send_queue();
    endtask

    initial begin
        logic [7:0] ftype;
        int r;
        stall_en = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every form, finish, bad form, bad hex, bad crlf, cancel, escaped form
        send_frame(HF_BIN16, 8'd2, 4);
        send_frame(HF_HEX16, 8'd4, 3);
        send_frame(HF_BIN32, 8'd10, 3);
        send_frame(HF_BIN16, TYPE_FIN, 0);
        send_frame(HF_HEX16, 8'hff, 0);
        frame_q = '{ZPAD, ZDLE, 8'h44, ZPAD, ZDLE, FORM_HEX16, 8'h30, 8'h67,
                    ZPAD, ZDLE, ZDLE, 8'h01, 8'h11, 8'h93, ZDLE, ZDLE, ZDLE, ZDLE, ZDLE,
                    8'h00, 8'h7f, 8'h80, 8'hff};
        send_queue();
        put_header(HF_HEX16, 8'd1, 32'h0, 0);
        void'(frame_q.pop_back());
        frame_q.push_back(8'h0b);
        send_queue();

        // all-ones mask, then a crc-32 subpacket
        write_mask(20'hfffff);
        put_header(HF_BIN32, 8'd0, 32'hffffffff, 0);
        send_queue();
        put_subpacket(1, 16, 2'd3, 0);
        send_queue();

        // random frames with mask changes between phases
        for (int ph = 0; ph < 4; ph++) begin
            write_mask(ph == 0 ? 20'h0 : ph == 1 ? 20'($urandom)
                                       : ph == 2 ? 20'h00414 : 20'hfffff);
            stall_en = ph != 3;
            for (int k = 0; k < 5; k++) begin
                r = $urandom_range(0, 9);
                ftype = r == 0 ? TYPE_FIN : r == 1 ? 8'($urandom)
                                                   : 8'($urandom_range(0, 19));
                if (r == 2) begin
                    repeat ($urandom_range(1, 8)) begin
                        frame_q.push_back(8'($urandom_range(0, 255)));
                    end
                    send_queue();
                end else
                    send_frame(2'($urandom_range(0, 2)), ftype, 12);
            end
            drain();
        end
        stall_en = 1;

        drain();
        $display("sent %0d bytes, checked %0d events over four mask settings",
            n_bytes, sb.n_events);
        $display("covered all header forms, nak cases, cancel, finish and chained subpackets");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
